// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never hold while out of reset.
`define SFR_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sfr assertion failed");

// Flag a consequent that fails to follow its antecedent in the same cycle.
`define SFR_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sfr assertion failed");

`endif

// ===== rtl/sfr_pkg.sv =====
// Types and constants shared by the sFlow record parser.
`default_nettype none
package sfr_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    localparam logic [1:0]  CFG_FLOW_FORMAT = 2'd0;
    localparam logic [1:0]  CFG_RAW_FORMAT  = 2'd1;
    localparam logic [1:0]  CFG_ETH_PROTO   = 2'd2;

    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    localparam logic [1:0]  KIND_OTHER = 2'd0;
    localparam logic [1:0]  KIND_IPV4  = 2'd1;
    localparam logic [1:0]  KIND_IPV6  = 2'd2;

    localparam logic [6:0]  IPV4_OVERHEAD = 7'd34;
    localparam logic [6:0]  IPV6_OVERHEAD = 7'd40;

    typedef enum logic [4:0] {
        PH_HDR0, PH_AGENT, PH_HDR1, PH_SFORMAT, PH_SLEN_FLOW, PH_SLEN_OTHER,
        PH_FLOWHDR, PH_NREC, PH_RFORMAT, PH_RLEN_RAW, PH_RLEN_OTHER,
        PH_RPROTO, PH_RAW_ETH, PH_RAW_OTHER, PH_MACS, PH_ETYPE, PH_VLAN,
        PH_IP4, PH_IP6HDR, PH_IP6ADDR, PH_RSKIP, PH_SSKIP, PH_DONE
    } sfr_phase_t;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_GO, ACT_NEXT_SAMPLE, ACT_END_SAMPLE,
        ACT_NEXT_RECORD, ACT_END_RECORD
    } sfr_act_t;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [1:0]  net_kind;
        logic [11:0] vlan_tag;
        logic [63:0] src_ip_high;
        logic [63:0] src_ip_low;
        logic [63:0] dst_ip_high;
        logic [63:0] dst_ip_low;
        logic [15:0] ip_length;
        logic [31:0] sample_rate;
        logic        status;
    } sfr_event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sfr_fifo_stat_t;

endpackage
`default_nettype wire

// ===== rtl/sfr_front.sv =====
// Byte-level datagram walker: tracks sample/record structure, emits record and truncation events.
`default_nettype none
`include "assert_macros.svh"
module sfr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              end_of_datagram,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output logic                   ev_valid,
    output sfr_pkg::sfr_event_t    ev
);

    sfr_pkg::sfr_phase_t phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;
    logic        agent6_reg, agent6_next;
    logic [31:0] samp_reg, samp_next, rec_reg, rec_next;
    logic [31:0] slen_reg, slen_next, rlen_reg, rlen_next;
    logic [31:0] rate_reg, rate_next;
    logic [47:0] dmac_reg, dmac_next, smac_reg, smac_next;
    logic [11:0] vlan_reg, vlan_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] len_reg, len_next;
    logic [63:0] src_lo_reg, src_lo_next, src_hi_reg, src_hi_next;
    logic [63:0] dst_lo_reg, dst_lo_next, dst_hi_reg, dst_hi_next;
    logic [31:0] flow_fmt_reg, raw_fmt_reg, eth_proto_reg;

    function automatic logic [5:0] phase_len(sfr_pkg::sfr_phase_t p, logic agent6);
        logic [5:0] n;
        case (p)
            sfr_pkg::PH_HDR0:      n = 6'd8;
            sfr_pkg::PH_AGENT:     n = agent6 ? 6'd16 : 6'd4;
            sfr_pkg::PH_HDR1:      n = 6'd16;
            sfr_pkg::PH_FLOWHDR:   n = 6'd28;
            sfr_pkg::PH_RAW_ETH,
            sfr_pkg::PH_RAW_OTHER,
            sfr_pkg::PH_MACS:      n = 6'd12;
            sfr_pkg::PH_ETYPE:     n = 6'd2;
            sfr_pkg::PH_IP4:       n = 6'd20;
            sfr_pkg::PH_IP6HDR:    n = 6'd8;
            sfr_pkg::PH_IP6ADDR:   n = 6'd32;
            default:               n = 6'd4;
        endcase
        return n;
    endfunction

    always_comb
    begin
        logic [31:0]         a;
        logic                done;
        logic                emit;
        logic                trunc;
        sfr_pkg::sfr_act_t   act;
        sfr_pkg::sfr_phase_t tgt;
        logic [15:0]         et;

        a    = {acc_reg[23:0], data_byte};
        done = 1'b0;
        emit = 1'b0;
        trunc = 1'b0;
        act  = sfr_pkg::ACT_NONE;
        tgt  = phase_reg;
        et   = 16'd0;

        phase_next = phase_reg;  idx_next = idx_reg;      acc_next = acc_reg;
        agent6_next = agent6_reg; samp_next = samp_reg;   rec_next = rec_reg;
        slen_next = slen_reg;    rlen_next = rlen_reg;    rate_next = rate_reg;
        dmac_next = dmac_reg;    smac_next = smac_reg;    vlan_next = vlan_reg;
        kind_next = kind_reg;    len_next = len_reg;
        src_lo_next = src_lo_reg; src_hi_next = src_hi_reg;
        dst_lo_next = dst_lo_reg; dst_hi_next = dst_hi_reg;
        ev_valid = 1'b0;
        ev = '0;

        if (accept)
        begin
            if (phase_reg >= sfr_pkg::PH_FLOWHDR && phase_reg <= sfr_pkg::PH_SSKIP
                && slen_reg != 32'd0)
                slen_next = slen_reg - 32'd1;
            if (phase_reg >= sfr_pkg::PH_RPROTO && phase_reg <= sfr_pkg::PH_RSKIP
                && rlen_reg != 32'd0)
                rlen_next = rlen_reg - 32'd1;

            if (phase_reg == sfr_pkg::PH_RSKIP)
            begin
                if (rlen_next == 32'd0)
                    act = sfr_pkg::ACT_NEXT_RECORD;
            end
            else if (phase_reg == sfr_pkg::PH_SSKIP)
            begin
                if (slen_next == 32'd0)
                    act = sfr_pkg::ACT_NEXT_SAMPLE;
            end
            else if (phase_reg != sfr_pkg::PH_DONE)
            begin
                acc_next = a;
                idx_next = idx_reg + 5'd1;
                done = ({1'b0, idx_reg} + 6'd1) >= phase_len(phase_reg, agent6_reg);

                if (phase_reg == sfr_pkg::PH_FLOWHDR && idx_reg == 5'd11)
                    rate_next = a;
                if (phase_reg == sfr_pkg::PH_MACS)
                begin
                    if (idx_reg < 5'd6)
                        dmac_next = {dmac_reg[39:0], data_byte};
                    else
                        smac_next = {smac_reg[39:0], data_byte};
                end
                if (phase_reg == sfr_pkg::PH_IP4)
                begin
                    if (idx_reg == 5'd3)
                        len_next = a[15:0];
                    if (idx_reg >= 5'd12 && idx_reg < 5'd16)
                        src_lo_next = {32'd0, src_lo_reg[23:0], data_byte};
                    if (idx_reg >= 5'd16)
                        dst_lo_next = {32'd0, dst_lo_reg[23:0], data_byte};
                end
                if (phase_reg == sfr_pkg::PH_IP6HDR && idx_reg == 5'd7)
                    len_next = a[31:16];
                if (phase_reg == sfr_pkg::PH_IP6ADDR)
                begin
                    case ({idx_reg[4], idx_reg[3]})
                        2'b00:   src_hi_next = {src_hi_reg[55:0], data_byte};
                        2'b01:   src_lo_next = {src_lo_reg[55:0], data_byte};
                        2'b10:   dst_hi_next = {dst_hi_reg[55:0], data_byte};
                        default: dst_lo_next = {dst_lo_reg[55:0], data_byte};
                    endcase
                end

                if (done)
                begin
                    case (phase_reg)
                        sfr_pkg::PH_HDR0:
                        begin
                            agent6_next = (a != 32'd1);
                            act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_AGENT;
                        end
                        sfr_pkg::PH_AGENT:
                        begin
                            act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_HDR1;
                        end
                        sfr_pkg::PH_HDR1:
                        begin
                            samp_next = a; act = sfr_pkg::ACT_NEXT_SAMPLE;
                        end
                        sfr_pkg::PH_SFORMAT:
                        begin
                            act = sfr_pkg::ACT_GO;
                            tgt = (a == flow_fmt_reg) ? sfr_pkg::PH_SLEN_FLOW
                                                      : sfr_pkg::PH_SLEN_OTHER;
                        end
                        sfr_pkg::PH_SLEN_FLOW:
                        begin
                            slen_next = a; act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_FLOWHDR;
                        end
                        sfr_pkg::PH_SLEN_OTHER:
                        begin
                            slen_next = a; act = sfr_pkg::ACT_END_SAMPLE;
                        end
                        sfr_pkg::PH_FLOWHDR:
                        begin
                            act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_NREC;
                        end
                        sfr_pkg::PH_NREC:
                        begin
                            rec_next = a; act = sfr_pkg::ACT_NEXT_RECORD;
                        end
                        sfr_pkg::PH_RFORMAT:
                        begin
                            act = sfr_pkg::ACT_GO;
                            tgt = (a == raw_fmt_reg) ? sfr_pkg::PH_RLEN_RAW
                                                     : sfr_pkg::PH_RLEN_OTHER;
                        end
                        sfr_pkg::PH_RLEN_RAW:
                        begin
                            rlen_next = a; act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_RPROTO;
                        end
                        sfr_pkg::PH_RLEN_OTHER:
                        begin
                            rlen_next = a; act = sfr_pkg::ACT_END_RECORD;
                        end
                        sfr_pkg::PH_RPROTO:
                        begin
                            act = sfr_pkg::ACT_GO;
                            tgt = (a == eth_proto_reg) ? sfr_pkg::PH_RAW_ETH
                                                       : sfr_pkg::PH_RAW_OTHER;
                        end
                        sfr_pkg::PH_RAW_ETH:
                        begin
                            // Clear everything a new Ethernet record reports.
                            dmac_next = '0; smac_next = '0; vlan_next = '0;
                            kind_next = sfr_pkg::KIND_OTHER; len_next = '0;
                            src_lo_next = '0; src_hi_next = '0;
                            dst_lo_next = '0; dst_hi_next = '0;
                            act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_MACS;
                        end
                        sfr_pkg::PH_RAW_OTHER: act = sfr_pkg::ACT_END_RECORD;
                        sfr_pkg::PH_MACS:
                        begin
                            act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_ETYPE;
                        end
                        sfr_pkg::PH_ETYPE, sfr_pkg::PH_VLAN:
                        begin
                            et = a[15:0];
                            if (phase_reg == sfr_pkg::PH_ETYPE && et == sfr_pkg::ETH_VLAN)
                            begin
                                act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_VLAN;
                            end
                            else
                            begin
                                if (phase_reg == sfr_pkg::PH_VLAN)
                                    vlan_next = a[27:16];
                                if (et == sfr_pkg::ETH_IPV4)
                                begin
                                    kind_next = sfr_pkg::KIND_IPV4;
                                    act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_IP4;
                                end
                                else if (et == sfr_pkg::ETH_IPV6)
                                begin
                                    kind_next = sfr_pkg::KIND_IPV6;
                                    act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_IP6HDR;
                                end
                                else
                                begin
                                    kind_next = sfr_pkg::KIND_OTHER;
                                    emit = 1'b1;
                                    act = sfr_pkg::ACT_END_RECORD;
                                end
                            end
                        end
                        sfr_pkg::PH_IP4, sfr_pkg::PH_IP6ADDR:
                        begin
                            emit = 1'b1; act = sfr_pkg::ACT_END_RECORD;
                        end
                        sfr_pkg::PH_IP6HDR:
                        begin
                            act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_IP6ADDR;
                        end
                        default: act = sfr_pkg::ACT_NONE;
                    endcase
                end
            end

            // Resolve the record/sample end cascade.
            if (act == sfr_pkg::ACT_END_RECORD)
            begin
                if (rlen_next != 32'd0)
                begin
                    act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_RSKIP;
                end
                else
                    act = sfr_pkg::ACT_NEXT_RECORD;
            end
            if (act == sfr_pkg::ACT_NEXT_RECORD)
            begin
                if (rec_next == 32'd0)
                    act = sfr_pkg::ACT_END_SAMPLE;
                else
                begin
                    rec_next = rec_next - 32'd1;
                    act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_RFORMAT;
                end
            end
            if (act == sfr_pkg::ACT_END_SAMPLE)
            begin
                if (slen_next != 32'd0)
                begin
                    act = sfr_pkg::ACT_GO; tgt = sfr_pkg::PH_SSKIP;
                end
                else
                    act = sfr_pkg::ACT_NEXT_SAMPLE;
            end
            if (act == sfr_pkg::ACT_NEXT_SAMPLE)
            begin
                act = sfr_pkg::ACT_GO;
                if (samp_next == 32'd0)
                    tgt = sfr_pkg::PH_DONE;
                else
                begin
                    samp_next = samp_next - 32'd1;
                    tgt = sfr_pkg::PH_SFORMAT;
                end
            end
            if (act == sfr_pkg::ACT_GO)
            begin
                phase_next = tgt; idx_next = '0; acc_next = '0;
            end

            ev.dest_mac    = dmac_next;
            ev.source_mac  = smac_next;
            ev.net_kind    = kind_next;
            ev.vlan_tag    = vlan_next;
            ev.src_ip_high = src_hi_next;
            ev.src_ip_low  = src_lo_next;
            ev.dst_ip_high = dst_hi_next;
            ev.dst_ip_low  = dst_lo_next;
            ev.ip_length   = len_next;
            ev.sample_rate = rate_next;
            ev.status      = 1'b0;

            if (end_of_datagram)
            begin
                trunc = (phase_next != sfr_pkg::PH_DONE) && !emit;
                if (trunc)
                begin
                    ev = '0;
                    ev.status = 1'b1;
                end
                // Return to the version field of the next datagram.
                phase_next = sfr_pkg::PH_HDR0; idx_next = '0; acc_next = '0;
                agent6_next = 1'b0; samp_next = '0; rec_next = '0;
                slen_next = '0; rlen_next = '0;
            end
            ev_valid = emit || trunc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfr_pkg::PH_HDR0; idx_reg <= '0; acc_reg <= '0;
            agent6_reg <= 1'b0; samp_reg <= '0; rec_reg <= '0;
            slen_reg <= '0; rlen_reg <= '0; rate_reg <= '0;
            dmac_reg <= '0; smac_reg <= '0; vlan_reg <= '0;
            kind_reg <= '0; len_reg <= '0;
            src_lo_reg <= '0; src_hi_reg <= '0; dst_lo_reg <= '0; dst_hi_reg <= '0;
            flow_fmt_reg <= 32'd1; raw_fmt_reg <= 32'd1; eth_proto_reg <= 32'd1;
        end
        else
        begin
            phase_reg <= phase_next; idx_reg <= idx_next; acc_reg <= acc_next;
            agent6_reg <= agent6_next; samp_reg <= samp_next; rec_reg <= rec_next;
            slen_reg <= slen_next; rlen_reg <= rlen_next; rate_reg <= rate_next;
            dmac_reg <= dmac_next; smac_reg <= smac_next; vlan_reg <= vlan_next;
            kind_reg <= kind_next; len_reg <= len_next;
            src_lo_reg <= src_lo_next; src_hi_reg <= src_hi_next;
            dst_lo_reg <= dst_lo_next; dst_hi_reg <= dst_hi_next;
            if (cfg_we && cfg_index == sfr_pkg::CFG_FLOW_FORMAT)
                flow_fmt_reg <= cfg_data;
            if (cfg_we && cfg_index == sfr_pkg::CFG_RAW_FORMAT)
                raw_fmt_reg <= cfg_data;
            if (cfg_we && cfg_index == sfr_pkg::CFG_ETH_PROTO)
                eth_proto_reg <= cfg_data;
        end
    end

    `SFR_ASSERT_IMPLY(a_done_no_samples, clk, rst_n, phase_reg == sfr_pkg::PH_DONE, samp_reg == 32'd0)
    `SFR_ASSERT_IMPLY(a_trunc_zero, clk, rst_n, ev_valid && ev.status, ev.net_kind == sfr_pkg::KIND_OTHER && ev.sample_rate == 32'd0)

endmodule
`default_nettype wire

// ===== rtl/sfr_fifo.sv =====
// Short event queue between the byte walker and the output stage.
`default_nettype none
`include "assert_macros.svh"
module sfr_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  sfr_pkg::sfr_event_t    push_data,
    input  wire logic              pop,
    output sfr_pkg::sfr_event_t    pop_data,
    output sfr_pkg::sfr_fifo_stat_t stat
);

    sfr_pkg::sfr_event_t mem_reg [sfr_pkg::FIFO_DEPTH];
    logic [sfr_pkg::FIFO_AW-1:0] wr_reg, rd_reg;
    logic [sfr_pkg::FIFO_AW:0]   cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == (sfr_pkg::FIFO_AW+1)'(sfr_pkg::FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_data   = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    `SFR_ASSERT_NEVER(a_push_full, clk, rst_n, push && stat.full)
    `SFR_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && stat.empty)

endmodule
`default_nettype wire

// ===== rtl/sfr_back.sv =====
// Output stage: scales the IP length plus a per-kind overhead by the sampling rate and holds the result item.
`default_nettype none
`include "assert_macros.svh"
module sfr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  sfr_pkg::sfr_fifo_stat_t stat,
    input  sfr_pkg::sfr_event_t    ev,
    output logic                   pop,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output sfr_pkg::sfr_event_t    out_ev,
    output logic [48:0]            scaled_bytes
);

    logic        valid_reg;
    sfr_pkg::sfr_event_t ev_reg;
    logic [48:0] scaled_reg, scaled_next;
    logic [16:0] wire_len;

    assign pop = !stat.empty && (!valid_reg || out_ready);

    always_comb
    begin
        wire_len = {1'b0, ev.ip_length} + ((ev.net_kind == sfr_pkg::KIND_IPV4)
                   ? 17'(sfr_pkg::IPV4_OVERHEAD) : 17'(sfr_pkg::IPV6_OVERHEAD));
        if (ev.net_kind == sfr_pkg::KIND_OTHER)
            scaled_next = '0;
        else
            scaled_next = 49'(wire_len * ev.sample_rate);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg     <= ev;
            scaled_reg <= scaled_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    assign out_valid    = valid_reg;
    assign out_ev       = ev_reg;
    assign scaled_bytes = scaled_reg;

    `SFR_ASSERT_IMPLY(a_status_unscaled, clk, rst_n, out_valid && out_ev.status, scaled_bytes == 49'd0)

endmodule
`default_nettype wire

// ===== rtl/sflow_flow_record_parser.sv =====
// Top level of the sFlow v5 flow-record parser.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | data_byte, end_of_datagram
//   out     | output    | out_valid/out_ready | record fields, scaled_bytes, status
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One byte is taken per cycle while in_ready is high; its parse step completes in that cycle.
// A result item passes through the four-entry event queue and then the
// length-times-rate multiply register before it reaches out_valid.
// in_ready drops only while the event queue is full; the output side stalls alone.
// Reset leaves the walker at the version field with all three format words at 1.
`default_nettype none
module sflow_flow_record_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_datagram,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [47:0]      dest_mac,
    output logic [47:0]      source_mac,
    output logic [1:0]       net_kind,
    output logic [11:0]      vlan_tag,
    output logic [63:0]      src_ip_high,
    output logic [63:0]      src_ip_low,
    output logic [63:0]      dst_ip_high,
    output logic [63:0]      dst_ip_low,
    output logic [15:0]      ip_length,
    output logic [31:0]      sample_rate,
    output logic [48:0]      scaled_bytes,
    output logic             status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic                    accept;
    logic                    ev_valid;
    logic                    pop;
    sfr_pkg::sfr_event_t     ev, q_ev, out_ev;
    sfr_pkg::sfr_fifo_stat_t stat;

    // Hold off bytes only when the queue has no room for an event.
    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    sfr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .end_of_datagram (end_of_datagram),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .ev_valid        (ev_valid),
        .ev              (ev)
    );

    sfr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev_valid),
        .push_data (ev),
        .pop       (pop),
        .pop_data  (q_ev),
        .stat      (stat)
    );

    sfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (stat),
        .ev           (q_ev),
        .pop          (pop),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_ev       (out_ev),
        .scaled_bytes (scaled_bytes)
    );

    assign dest_mac    = out_ev.dest_mac;
    assign source_mac  = out_ev.source_mac;
    assign net_kind    = out_ev.net_kind;
    assign vlan_tag    = out_ev.vlan_tag;
    assign src_ip_high = out_ev.src_ip_high;
    assign src_ip_low  = out_ev.src_ip_low;
    assign dst_ip_high = out_ev.dst_ip_high;
    assign dst_ip_low  = out_ev.dst_ip_low;
    assign ip_length   = out_ev.ip_length;
    assign sample_rate = out_ev.sample_rate;
    assign status      = out_ev.status;

endmodule
`default_nettype wire
